### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine package
// Shared types, codes and constants of the I2C master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned WBUF_DEPTH_DEF = 16;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd254;

    // Operation codes carried by an input word; code three acts as a plain tick.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WR_REGS  = 2'd0,
        KIND_RD_REGS  = 2'd1,
        KIND_WR_BYTES = 2'd2,
        KIND_RD_BYTES = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_NACK    = 3'd2,
        ST_NODEV   = 3'd3,
        ST_NOREG   = 3'd4,
        ST_INVALID = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ROLE_ADDR   = 2'd0,
        ROLE_REG    = 2'd1,
        ROLE_DATA   = 2'd2,
        ROLE_READDR = 2'd3
    } t_role;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_TX_SET    = 4'd2,
        PH_TX_HIGH   = 4'd3,
        PH_TX_HOLD   = 4'd4,
        PH_ACK_WAIT  = 4'd5,
        PH_ACK_END   = 4'd6,
        PH_RESTART   = 4'd7,
        PH_RX_HIGH   = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_RACK_LOW  = 4'd10,
        PH_RACK_HIGH = 4'd11,
        PH_STOP_A    = 4'd12,
        PH_STOP_B    = 4'd13,
        PH_STOP_C    = 4'd14
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        t_kind       kind;
        logic [6:0]  target_addr;
        logic [7:0]  sub_addr;
        logic [15:0] byte_count;
        logic [7:0]  write_data;
        logic        scl_in;
        logic        sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        t_status    status;
        logic       active;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [15:0] bytes_left;
        logic [7:0]  ack_wait_count;
        t_kind       req_kind;
        logic [6:0]  req_dev;
        logic [7:0]  req_reg;
        t_role       byte_role;
        t_status     end_status;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_IDLE,
        bit_index:      4'd0,
        shift_byte:     8'd0,
        bytes_left:     16'd0,
        ack_wait_count: 8'd0,
        req_kind:       KIND_WR_REGS,
        req_dev:        7'd0,
        req_reg:        8'd0,
        byte_role:      ROLE_ADDR,
        end_status:     ST_OK
    };

endpackage

### rtl/i2cm_wbuf.sv
// ----------------------------------------------------------------------------
// I2C master write buffer
// Single write port, single registered read port byte memory.
// ----------------------------------------------------------------------------
module i2cm_wbuf #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/i2cm_step.sv
// ----------------------------------------------------------------------------
// I2C master tick step logic
// Next state and line drive for one half-bit tick of the transaction engine.
// ----------------------------------------------------------------------------
module i2cm_step #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned FW    = 5
) (
    input  i2cm_pkg::t_state  i_state,
    input  i2cm_pkg::t_item   i_item,
    input  logic [7:0]        i_ack_timeout,
    input  logic [FW-1:0]     i_fill,
    input  logic [FW-1:0]     i_rd_index,
    input  logic [7:0]        i_buf_data,
    output i2cm_pkg::t_state  o_state,
    output logic [FW-1:0]     o_fill,
    output logic [FW-1:0]     o_rd_index,
    output logic              o_buf_we,
    output i2cm_pkg::t_result o_res
);

    import i2cm_pkg::*;

    t_state        n_st;
    t_result       res;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] n_idx;
    logic          buf_we;
    logic          cur_bit;
    logic [3:0]    bit_inc;
    logic [7:0]    wait_inc;
    logic [7:0]    rx_shift;
    logic [7:0]    next_data;
    logic          is_write_kind;
    logic          req_write_kind;
    logic [15:0]   fill_ext;

    assign cur_bit        = i_state.shift_byte[7];
    assign bit_inc        = i_state.bit_index + 4'd1;
    assign wait_inc       = (i_state.ack_wait_count != 8'hFF) ?
                            i_state.ack_wait_count + 8'd1 : i_state.ack_wait_count;
    assign rx_shift       = {i_state.shift_byte[6:0], i_item.sda_in};
    // Entries at or past the depth are never reached while the count is checked.
    assign next_data      = (i_rd_index < FW'(DEPTH)) ? i_buf_data : 8'h00;
    assign is_write_kind  = (i_item.kind == KIND_WR_REGS) || (i_item.kind == KIND_WR_BYTES);
    assign req_write_kind = (i_state.req_kind == KIND_WR_REGS) ||
                            (i_state.req_kind == KIND_WR_BYTES);
    assign fill_ext       = 16'(i_fill);

    always_comb begin
        n_st           = i_state;
        n_fill         = i_fill;
        n_idx          = i_rd_index;
        buf_we         = 1'b0;
        res.scl_out    = 1'b1;
        res.sda_out    = 1'b1;
        res.read_data  = 8'h00;
        res.read_valid = 1'b0;
        res.done_res   = 1'b0;
        res.status     = ST_OK;

        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_item.operation == OP_LOAD) begin
                    if (i_fill < FW'(DEPTH)) begin
                        buf_we = 1'b1;
                        n_fill = i_fill + FW'(1);
                    end
                end else if (i_item.operation == OP_BEGIN) begin
                    if ((i_item.byte_count == 16'd0) ||
                        (is_write_kind && (i_item.byte_count > fill_ext))) begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                    end else if (!i_item.scl_in || !i_item.sda_in) begin
                        res.done_res = 1'b1;
                        res.status   = ST_BUSY;
                    end else begin
                        n_st.req_kind   = i_item.kind;
                        n_st.req_dev    = i_item.target_addr;
                        n_st.req_reg    = i_item.sub_addr;
                        n_st.bytes_left = i_item.byte_count;
                        n_idx           = '0;
                        n_st.end_status = ST_OK;
                        n_st.byte_role  = ROLE_ADDR;
                        n_st.phase      = PH_START;
                    end
                end
            end
            PH_START: begin
                res.sda_out     = 1'b0;
                n_st.shift_byte = {i_state.req_dev,
                                   (i_state.byte_role == ROLE_READDR) ||
                                   (i_state.req_kind == KIND_RD_BYTES)};
                n_st.bit_index  = 4'd0;
                n_st.phase      = PH_TX_SET;
            end
            PH_TX_SET: begin
                res.scl_out = 1'b0;
                res.sda_out = cur_bit;
                n_st.phase  = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                res.sda_out = cur_bit;
                n_st.phase  = PH_TX_HOLD;
            end
            PH_TX_HOLD: begin
                res.scl_out     = 1'b0;
                res.sda_out     = (i_state.bit_index >= 4'd7) ? 1'b1 : cur_bit;
                n_st.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                n_st.bit_index  = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_st.ack_wait_count = 8'd0;
                    n_st.phase          = PH_ACK_WAIT;
                end else begin
                    n_st.phase = PH_TX_SET;
                end
            end
            PH_ACK_WAIT: begin
                if (!i_item.sda_in) begin
                    n_st.phase = PH_ACK_END;
                end else begin
                    n_st.ack_wait_count = wait_inc;
                    if (wait_inc >= i_ack_timeout) begin
                        unique case (i_state.byte_role)
                            ROLE_REG:  n_st.end_status = ST_NOREG;
                            ROLE_DATA: n_st.end_status = ST_NACK;
                            default:   n_st.end_status = ST_NODEV;
                        endcase
                        n_st.phase = PH_ACK_END;
                    end
                end
            end
            PH_ACK_END: begin
                res.scl_out = 1'b0;
                if (i_state.end_status != ST_OK) begin
                    n_st.phase = PH_STOP_A;
                end else begin
                    unique case (i_state.byte_role)
                        ROLE_ADDR: begin
                            if ((i_state.req_kind == KIND_WR_REGS) ||
                                (i_state.req_kind == KIND_RD_REGS)) begin
                                n_st.shift_byte = i_state.req_reg;
                                n_st.byte_role  = ROLE_REG;
                                n_st.bit_index  = 4'd0;
                                n_st.phase      = PH_TX_SET;
                            end else if (i_state.req_kind == KIND_WR_BYTES) begin
                                n_st.shift_byte = next_data;
                                n_idx           = i_rd_index + FW'(1);
                                n_st.byte_role  = ROLE_DATA;
                                n_st.bit_index  = 4'd0;
                                n_st.phase      = PH_TX_SET;
                            end else begin
                                n_st.bit_index  = 4'd0;
                                n_st.shift_byte = 8'd0;
                                n_st.phase      = PH_RX_HIGH;
                            end
                        end
                        ROLE_REG: begin
                            if (i_state.req_kind == KIND_RD_REGS) begin
                                n_st.byte_role = ROLE_READDR;
                                n_st.phase     = PH_RESTART;
                            end else begin
                                n_st.shift_byte = next_data;
                                n_idx           = i_rd_index + FW'(1);
                                n_st.byte_role  = ROLE_DATA;
                                n_st.bit_index  = 4'd0;
                                n_st.phase      = PH_TX_SET;
                            end
                        end
                        ROLE_DATA: begin
                            if (i_state.bytes_left <= 16'd1) begin
                                n_st.bytes_left = 16'd0;
                                n_st.phase      = PH_STOP_A;
                            end else begin
                                n_st.bytes_left = i_state.bytes_left - 16'd1;
                                n_st.shift_byte = next_data;
                                n_idx           = i_rd_index + FW'(1);
                                n_st.bit_index  = 4'd0;
                                n_st.phase      = PH_TX_SET;
                            end
                        end
                        default: begin
                            n_st.bit_index  = 4'd0;
                            n_st.shift_byte = 8'd0;
                            n_st.phase      = PH_RX_HIGH;
                        end
                    endcase
                end
            end
            PH_RESTART: begin
                n_st.phase = PH_START;
            end
            PH_RX_HIGH: begin
                n_st.shift_byte = rx_shift;
                n_st.bit_index  = bit_inc;
                if (bit_inc >= 4'd8) begin
                    res.read_valid = 1'b1;
                    res.read_data  = rx_shift;
                end
                n_st.phase = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                res.scl_out = 1'b0;
                n_st.phase  = (i_state.bit_index >= 4'd8) ? PH_RACK_LOW : PH_RX_HIGH;
            end
            PH_RACK_LOW: begin
                res.scl_out = 1'b0;
                res.sda_out = (i_state.bytes_left > 16'd1) ? 1'b0 : 1'b1;
                n_st.phase  = PH_RACK_HIGH;
            end
            PH_RACK_HIGH: begin
                res.sda_out = (i_state.bytes_left > 16'd1) ? 1'b0 : 1'b1;
                if (i_state.bytes_left <= 16'd1) begin
                    n_st.bytes_left = 16'd0;
                    n_st.phase      = PH_STOP_A;
                end else begin
                    n_st.bytes_left = i_state.bytes_left - 16'd1;
                    n_st.bit_index  = 4'd0;
                    n_st.shift_byte = 8'd0;
                    n_st.phase      = PH_RX_HIGH;
                end
            end
            PH_STOP_A: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                n_st.phase  = PH_STOP_B;
            end
            PH_STOP_B: begin
                res.sda_out = 1'b0;
                n_st.phase  = PH_STOP_C;
            end
            PH_STOP_C: begin
                res.done_res = 1'b1;
                res.status   = i_state.end_status;
                if (req_write_kind) begin
                    n_fill = '0;
                    n_idx  = '0;
                end
                n_st.phase = PH_IDLE;
            end
            default: begin
                n_st.phase = PH_IDLE;
            end
        endcase

        res.active = (n_st.phase != PH_IDLE);
    end

    assign o_state    = n_st;
    assign o_fill     = n_fill;
    assign o_rd_index = n_idx;
    assign o_buf_we   = buf_we;
    assign o_res      = res;

endmodule

### rtl/i2c_master_transaction_engine_core.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine core
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless stalled; the state update is single pass.
// Reset: synchronous active-low; the engine returns idle, the buffer empties.
// ----------------------------------------------------------------------------
//
// Each input word is one half-bit tick of an open-drain I2C bus. It carries
// the sampled SCL and SDA levels and may start a transaction or append one
// byte to the write buffer. Each tick yields exactly one result word with the
// line drives, any received byte and the end-of-transaction status.
//
// Structure: an input register holds the accepted word, the step logic
// computes the next engine state and the result from it in one pass, and the
// result register presents the word downstream. The engine state advances
// only when a word moves from the input register into the result register,
// so stalls on either side never change the sequence of ticks the engine sees.
// The input register keeps accepting while the result register holds a word
// that has not been taken yet, as long as that word can move on.
//
// The write buffer is a small memory with a registered read port. Its read
// address is the buffer read index, which never changes in the cycle just
// before it is used, so the registered read data is always current when a
// data byte is loaded for sending. Writes happen only while idle.
//
module i2c_master_transaction_engine_core #(
    parameter int unsigned WRITE_BUFFER_DEPTH = i2cm_pkg::WBUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_target_addr,
    input  logic [7:0]  i_sub_addr,
    input  logic [15:0] i_byte_count,
    input  logic [7:0]  i_write_data,
    input  logic        i_scl_in,
    input  logic        i_sda_in,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic        o_active
);

    import i2cm_pkg::*;

    // Fill and read counters must be able to hold the depth itself.
    localparam int unsigned FW = $clog2(WRITE_BUFFER_DEPTH + 1);
    localparam int unsigned AW = (WRITE_BUFFER_DEPTH > 1) ? $clog2(WRITE_BUFFER_DEPTH) : 1;

    logic [7:0]    r_ack_timeout;
    logic          r_in_valid;
    t_item         r_in;
    logic          r_out_valid;
    t_result       r_out;
    t_state        r_state;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_rd_index;

    t_state        n_state;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] n_rd_index;
    t_result       n_out;
    logic          buf_we;
    logic [7:0]    buf_rdata;
    logic          advance;
    logic          in_accept;

    // A word steps the engine when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.operation   <= i_operation;
            r_in.kind        <= t_kind'(i_kind);
            r_in.target_addr <= i_target_addr;
            r_in.sub_addr    <= i_sub_addr;
            r_in.byte_count  <= i_byte_count;
            r_in.write_data  <= i_write_data;
            r_in.scl_in      <= i_scl_in;
            r_in.sda_in      <= i_sda_in;
        end
    end

    // Engine state, updated once per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= STATE_RESET;
            r_fill     <= '0;
            r_rd_index <= '0;
        end else if (advance) begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_rd_index <= n_rd_index;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    i2cm_wbuf #(
        .DEPTH (WRITE_BUFFER_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we && advance),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_in.write_data),
        .i_raddr (r_rd_index[AW-1:0]),
        .o_rdata (buf_rdata)
    );

    i2cm_step #(
        .DEPTH (WRITE_BUFFER_DEPTH),
        .FW    (FW)
    ) u_step (
        .i_state       (r_state),
        .i_item        (r_in),
        .i_ack_timeout (r_ack_timeout),
        .i_fill        (r_fill),
        .i_rd_index    (r_rd_index),
        .i_buf_data    (buf_rdata),
        .o_state       (n_state),
        .o_fill        (n_fill),
        .o_rd_index    (n_rd_index),
        .o_buf_we      (buf_we),
        .o_res         (n_out)
    );

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_out.scl_out;
    assign o_sda_out    = r_out.sda_out;
    assign o_read_data  = r_out.read_data;
    assign o_read_valid = r_out.read_valid;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;
    assign o_active     = r_out.active;

endmodule

### test/tb_i2c_master_transaction_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction engine testbench
// Drives half-bit bus ticks through the valid/stall input channel, plays the
// target side on the sampled SDA line, and checks every result word against
// a tick-accurate prediction of the engine, over several ACK timeout values.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_engine_core;
    import i2cm_pkg::*;

    localparam int WBUF = WBUF_DEPTH_DEF;

    // Operation code three is not named in the package; the engine treats it
    // as a plain tick.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // One row of the directed table. Where typed is set, want is the word the
    // engine must return; otherwise the prediction supplies it.
    typedef struct {
        t_item   it;
        logic    typed;
        t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_item       drv = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    logic        o_scl_out;
    logic        o_sda_out;
    logic [7:0]  o_read_data;
    logic        o_read_valid;
    logic        o_done_res;
    logic [2:0]  o_status;
    logic        o_active;

    // Predicted engine state. It follows the accepted words one tick at a time.
    t_phase      ph;
    logic [3:0]  bidx;
    logic [7:0]  shreg;
    logic [15:0] left;
    logic [7:0]  ackcnt;
    logic [7:0]  ack_limit;
    t_kind       rq_kind;
    logic [6:0]  rq_dev;
    logic [7:0]  rq_reg;
    logic [7:0]  wbuf [WBUF];
    int          fill;
    int          rd_idx;
    t_role       role;
    t_status     end_st;

    // Line drives and status words still owed by the engine, oldest first.
    t_result     bus_words_due [$];

    int          mismatches = 0;
    int          words_sent = 0;
    int          bytes_rx = 0;
    int          ends_seen [6];
    int          send_calm = 0;
    int          recv_calm = 0;
    int          stall_left = 0;
    int          nack_pct = 10;
    logic        hold_nack = 1'b0;

    i2c_master_transaction_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (drv.operation),
        .i_kind        (drv.kind),
        .i_target_addr (drv.target_addr),
        .i_sub_addr    (drv.sub_addr),
        .i_byte_count  (drv.byte_count),
        .i_write_data  (drv.write_data),
        .i_scl_in      (drv.scl_in),
        .i_sda_in      (drv.sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_read_data   (o_read_data),
        .o_read_valid  (o_read_valid),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_active      (o_active)
    );

    always #6 i_clk = ~i_clk;

    // Run limit, far beyond the slowest legal run even with long NACK slots.
    initial begin
        #10_000_000;
        $display("tb_i2c_master_transaction_engine_core: errors");
        $finish;
    end

    function automatic t_result drive_word(input logic scl, input logic sda, input logic done,
                                           input t_status st, input logic act);
        t_result res;
        res.scl_out    = scl;
        res.sda_out    = sda;
        res.read_data  = 8'h00;
        res.read_valid = 1'b0;
        res.done_res   = done;
        res.status     = st;
        res.active     = act;
        return res;
    endfunction

    function automatic logic is_write(input t_kind kind);
        return kind == KIND_WR_REGS || kind == KIND_WR_BYTES;
    endfunction

    // Waits between words: mostly a fresh random draw, now and then a
    // stretch of back-to-back words.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // ------------------------------------------------------------------------
    // Engine prediction
    // ------------------------------------------------------------------------

    function automatic void clear_engine();
        ph        = PH_IDLE;
        bidx      = 4'd0;
        shreg     = 8'd0;
        left      = 16'd0;
        ackcnt    = 8'd0;
        ack_limit = ACK_TIMEOUT_RESET;
        rq_kind   = KIND_WR_REGS;
        rq_dev    = 7'd0;
        rq_reg    = 8'd0;
        fill      = 0;
        rd_idx    = 0;
        role      = ROLE_ADDR;
        end_st    = ST_OK;
        for (int k = 0; k < WBUF; k++) wbuf[k] = 8'h00;
    endfunction

    function automatic void load_byte(input logic [7:0] value, input t_role which);
        shreg = value;
        role  = which;
        bidx  = 4'd0;
        ph    = PH_TX_SET;
    endfunction

    // The next buffered byte goes out as data. Only entries below the fill
    // level are ever reached, because the count was checked at begin.
    function automatic void load_data();
        logic [7:0] value;
        value = (rd_idx < WBUF) ? wbuf[rd_idx] : 8'h00;
        rd_idx++;
        load_byte(value, ROLE_DATA);
    endfunction

    function automatic void start_receive();
        bidx  = 4'd0;
        shreg = 8'd0;
        ph    = PH_RX_HIGH;
    endfunction

    // Advances the predicted engine by one tick and returns the word it drives.
    function automatic t_result engine_tick(input t_item it);
        t_result res;
        logic    msb;
        res = drive_word(1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
        msb = shreg[7];
        case (ph)
            PH_IDLE: begin
                if (it.operation == OP_LOAD) begin
                    // A load into a full buffer is dropped.
                    if (fill < WBUF) begin
                        wbuf[fill] = it.write_data;
                        fill++;
                    end
                end else if (it.operation == OP_BEGIN) begin
                    if (it.byte_count == 16'd0 ||
                        (is_write(it.kind) && int'(it.byte_count) > fill)) begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                    end else if (!it.scl_in || !it.sda_in) begin
                        // Bus not idle: report busy without touching the lines.
                        res.done_res = 1'b1;
                        res.status   = ST_BUSY;
                    end else begin
                        rq_kind = it.kind;
                        rq_dev  = it.target_addr;
                        rq_reg  = it.sub_addr;
                        left    = it.byte_count;
                        rd_idx  = 0;
                        end_st  = ST_OK;
                        role    = ROLE_ADDR;
                        ph      = PH_START;
                    end
                end
            end
            PH_START: begin
                res.sda_out = 1'b0;
                load_byte({rq_dev, role == ROLE_READDR || rq_kind == KIND_RD_BYTES}, role);
            end
            PH_TX_SET: begin
                res.scl_out = 1'b0;
                res.sda_out = msb;
                ph = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                res.sda_out = msb;
                ph = PH_TX_HOLD;
            end
            PH_TX_HOLD: begin
                // SDA is released already on the low phase after the eighth bit.
                res.scl_out = 1'b0;
                res.sda_out = (bidx >= 4'd7) ? 1'b1 : msb;
                shreg = shreg << 1;
                bidx++;
                if (bidx >= 4'd8) begin
                    ackcnt = 8'd0;
                    ph = PH_ACK_WAIT;
                end else begin
                    ph = PH_TX_SET;
                end
            end
            PH_ACK_WAIT: begin
                if (!it.sda_in) begin
                    ph = PH_ACK_END;
                end else begin
                    if (ackcnt != 8'hFF) ackcnt++;
                    if (ackcnt >= ack_limit) begin
                        end_st = (role == ROLE_REG)  ? ST_NOREG :
                                 (role == ROLE_DATA) ? ST_NACK  : ST_NODEV;
                        ph = PH_ACK_END;
                    end
                end
            end
            PH_ACK_END: begin
                res.scl_out = 1'b0;
                if (end_st != ST_OK) begin
                    ph = PH_STOP_A;
                end else begin
                    case (role)
                        ROLE_ADDR: begin
                            if (rq_kind == KIND_WR_REGS || rq_kind == KIND_RD_REGS)
                                load_byte(rq_reg, ROLE_REG);
                            else if (rq_kind == KIND_WR_BYTES)
                                load_data();
                            else
                                start_receive();
                        end
                        ROLE_REG: begin
                            if (rq_kind == KIND_RD_REGS) begin
                                role = ROLE_READDR;
                                ph = PH_RESTART;
                            end else begin
                                load_data();
                            end
                        end
                        ROLE_DATA: begin
                            if (left <= 16'd1) begin
                                left = 16'd0;
                                ph = PH_STOP_A;
                            end else begin
                                left--;
                                load_data();
                            end
                        end
                        default: start_receive();
                    endcase
                end
            end
            PH_RESTART: ph = PH_START;
            PH_RX_HIGH: begin
                shreg = {shreg[6:0], it.sda_in};
                bidx++;
                if (bidx >= 4'd8) begin
                    res.read_valid = 1'b1;
                    res.read_data  = shreg;
                    bytes_rx++;
                end
                ph = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                res.scl_out = 1'b0;
                ph = (bidx >= 4'd8) ? PH_RACK_LOW : PH_RX_HIGH;
            end
            PH_RACK_LOW: begin
                // ACK every byte but the last, which gets a NACK.
                res.scl_out = 1'b0;
                res.sda_out = !(left > 16'd1);
                ph = PH_RACK_HIGH;
            end
            PH_RACK_HIGH: begin
                res.sda_out = !(left > 16'd1);
                if (left <= 16'd1) begin
                    left = 16'd0;
                    ph = PH_STOP_A;
                end else begin
                    left--;
                    start_receive();
                end
            end
            PH_STOP_A: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                ph = PH_STOP_B;
            end
            PH_STOP_B: begin
                res.sda_out = 1'b0;
                ph = PH_STOP_C;
            end
            PH_STOP_C: begin
                res.done_res = 1'b1;
                res.status   = end_st;
                // A finished write transaction empties the buffer for reuse.
                if (is_write(rq_kind)) begin
                    fill   = 0;
                    rd_idx = 0;
                end
                ph = PH_IDLE;
            end
            default: ph = PH_IDLE;
        endcase
        res.active = (ph != PH_IDLE);
        if (res.done_res) ends_seen[int'(res.status)]++;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic t_row mk_row(input logic [1:0] op, input t_kind kind, input int dev_v,
                                    input int reg_v, input int cnt_v, input int wd_v,
                                    input logic scl, input logic sda, input logic typed,
                                    input t_result want);
        t_row row;
        row.it.operation   = op;
        row.it.kind        = kind;
        row.it.target_addr = 7'(dev_v);
        row.it.sub_addr    = 8'(reg_v);
        row.it.byte_count  = 16'(cnt_v);
        row.it.write_data  = 8'(wd_v);
        row.it.scl_in      = scl;
        row.it.sda_in      = sda;
        row.typed          = typed;
        row.want           = want;
        return row;
    endfunction

    // Builds the next word from the predicted state, so that most of the
    // traffic is well-formed transactions and the target answers in step.
    function automatic t_item next_word();
        t_item it;
        int    pick;
        int    top;
        it.operation   = OP_TICK;
        it.kind        = t_kind'(2'($urandom_range(0, 3)));
        it.target_addr = 7'($urandom_range(0, 127));
        it.sub_addr    = 8'($urandom_range(0, 255));
        it.byte_count  = 16'($urandom_range(0, 65535));
        it.write_data  = 8'($urandom_range(0, 255));
        it.scl_in      = 1'($urandom_range(0, 1));
        it.sda_in      = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (ph == PH_IDLE) begin
            if (pick < 8) begin
                it.operation = (pick < 4) ? OP_SPARE : OP_TICK;
            end else if ((fill < WBUF && pick < 50) || pick < 12) begin
                it.operation = OP_LOAD;
            end else begin
                it.operation = OP_BEGIN;
                it.scl_in = 1'b1;
                it.sda_in = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    it.byte_count = 16'd0;
                end else if (is_write(it.kind)) begin
                    if (pick < 12 || fill == 0) begin
                        it.byte_count = 16'($urandom_range(fill + 1, 65535));
                    end else begin
                        top = (fill > 4 && pick < 85) ? 4 : fill;
                        it.byte_count = 16'($urandom_range(1, top));
                    end
                end else begin
                    it.byte_count = 16'($urandom_range(1, 5));
                end
                // Now and then one or both of the lines are held low by someone else.
                if ($urandom_range(0, 19) == 0)
                    {it.scl_in, it.sda_in} = 2'($urandom_range(0, 2));
            end
        end else begin
            // Begin and load words are ignored while a transaction runs.
            it.operation = (pick < 85) ? OP_TICK :
                           (pick < 90) ? OP_BEGIN :
                           (pick < 95) ? OP_LOAD : OP_SPARE;
            if (ph == PH_ACK_WAIT) begin
                if (ackcnt == 8'd0) hold_nack = ($urandom_range(0, 99) < nack_pct);
                it.sda_in = hold_nack ? 1'b1 : ($urandom_range(0, 2) == 0);
            end
        end
        return it;
    endfunction

    // Presents one word after a random gap and holds it until it is taken.
    task automatic push_word(input t_item it, input logic typed, input t_result want);
        int      gap;
        t_result owed;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drv      <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        owed = engine_tick(it);
        bus_words_due.push_back(typed ? want : owed);
        words_sent++;
    endtask

    // Stops sending and lets every owed word come back, plus the pipeline depth.
    task automatic settle();
        in_valid <= 1'b0;
        while (bus_words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, and a check of every accepted word
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_w;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                got.scl_out    = o_scl_out;
                got.sda_out    = o_sda_out;
                got.read_data  = o_read_data;
                got.read_valid = o_read_valid;
                got.done_res   = o_done_res;
                got.status     = t_status'(o_status);
                got.active     = o_active;
                if (bus_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: word arrived with nothing owed: %h", $realtime, got);
                end else begin
                    exp_w = bus_words_due.pop_front();
                    if (got !== exp_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected scl=%0d sda=%0d rd=%02h rv=%0d ",
                                      "done=%0d st=%0d act=%0d, got scl=%0d sda=%0d rd=%02h ",
                                      "rv=%0d done=%0d st=%0d act=%0d"}, $realtime,
                                     exp_w.scl_out, exp_w.sda_out, exp_w.read_data,
                                     exp_w.read_valid, exp_w.done_res, exp_w.status,
                                     exp_w.active, got.scl_out, got.sda_out, got.read_data,
                                     got.read_valid, got.done_res, got.status, got.active);
                    end
                end
                stall_left = draw_wait(recv_calm);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        t_row        rows [$];
        t_result     idle_w;
        t_result     none_w;
        int unsigned limits [6];
        int          sent;

        clear_engine();
        for (int k = 0; k < 6; k++) ends_seen[k] = 0;
        idle_w = drive_word(1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
        none_w = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: idle ticks, every early rejection, loads, and the
        // opening of a plain write to the highest address.
        rows.push_back(mk_row(OP_TICK, KIND_WR_REGS, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1, idle_w));
        rows.push_back(mk_row(OP_SPARE, KIND_RD_BYTES, 127, 255, 65535, 255, 1'b0, 1'b0,
                              1'b1, idle_w));
        rows.push_back(mk_row(OP_BEGIN, KIND_WR_REGS, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_RD_BYTES, 127, 255, 0, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_WR_BYTES, 5, 9, 1, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_RD_REGS, 0, 255, 1, 0, 1'b0, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_BUSY, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_RD_BYTES, 127, 0, 65535, 0, 1'b1, 1'b0, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_BUSY, 1'b0)));
        rows.push_back(mk_row(OP_LOAD, KIND_WR_REGS, 0, 0, 0, 255, 1'b1, 1'b1, 1'b1, idle_w));
        rows.push_back(mk_row(OP_LOAD, KIND_RD_BYTES, 127, 255, 65535, 0, 1'b0, 1'b0,
                              1'b1, idle_w));
        rows.push_back(mk_row(OP_BEGIN, KIND_WR_BYTES, 3, 3, 3, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_WR_REGS, 3, 3, 65535, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0)));
        rows.push_back(mk_row(OP_BEGIN, KIND_WR_BYTES, 127, 255, 2, 0, 1'b1, 1'b1, 1'b1,
                              drive_word(1'b1, 1'b1, 1'b0, ST_OK, 1'b1)));
        // START condition: SCL high with SDA pulled low.
        rows.push_back(mk_row(OP_TICK, KIND_WR_REGS, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1,
                              drive_word(1'b1, 1'b0, 1'b0, ST_OK, 1'b1)));
        rows.push_back(mk_row(OP_BEGIN, KIND_RD_REGS, 1, 1, 1, 0, 1'b1, 1'b1, 1'b0, none_w));
        rows.push_back(mk_row(OP_LOAD, KIND_WR_REGS, 0, 0, 0, 170, 1'b1, 1'b1, 1'b0, none_w));
        rows.push_back(mk_row(OP_SPARE, KIND_WR_BYTES, 64, 128, 32768, 85, 1'b0, 1'b1,
                              1'b0, none_w));
        for (int k = 0; k < 6; k++)
            rows.push_back(mk_row(OP_TICK, KIND_WR_REGS, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, none_w));
        foreach (rows[k]) push_word(rows[k].it, rows[k].typed, rows[k].want);

        // Random part over several ACK timeout values, both extremes included.
        // The first runs on the reset value; each later one is written with
        // the engine idle and nothing owed.
        limits = '{32'd254, 32'd1, 32'd0, 32'd255, 32'd0, 32'd30};
        limits[4] = $urandom_range(2, 12);
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                settle();
                cfg_wdata <= 8'(limits[p]);
                cfg_we    <= 1'b1;
                @(posedge i_clk);
                cfg_we    <= 1'b0;
                ack_limit = 8'(limits[p]);
            end
            // Long timeouts make a held-off ACK costly, so keep those rare.
            nack_pct = (limits[p] >= 200) ? 3 : 12;
            sent = 0;
            while (sent < 190 || ph != PH_IDLE) begin
                push_word(next_word(), 1'b0, none_w);
                sent++;
            end
        end
        settle();

        $display("run covered %0d words over 6 ACK timeout settings, %0d bytes read back",
                 words_sent, bytes_rx);
        $display("ends: ok %0d, busy %0d, data nack %0d, no device %0d, no register %0d, %s %0d",
                 ends_seen[0], ends_seen[1], ends_seen[2], ends_seen[3], ends_seen[4],
                 "invalid", ends_seen[5]);
        if (mismatches == 0) begin
            $display("tb_i2c_master_transaction_engine_core: clean");
        end else begin
            $display("tb_i2c_master_transaction_engine_core: errors");
        end
        $finish;
    end

endmodule
